[src/gbsm_pkg.sv]
// gbsm_pkg: types, codes and fixed widths for the grid binning block
// no dependencies
package gbsm_pkg;

   localparam int COORD_W = 16;
   localparam int CELL_W  = 15;
   localparam int GRID_W  = 7;
   localparam int CNT_W   = 15;
   localparam int AREA_W  = 6;
   localparam int IDX_W   = 14;
   localparam int QUO_W   = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_MERGE = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OUTSIDE = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_BAD_IDX = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_ROWS  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_COLS  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CELL_DEPTH = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CELL_WIDTH = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_POINTS = 3'd4;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic [IDX_W-1:0]         point_index;
   } req_type;

   typedef struct packed {
      logic [AREA_W-1:0] area;
      logic [CNT_W-1:0]  area_points;
      logic [1:0]        status;
   } rsp_type;

endpackage

[src/gbsm_div.sv]
// gbsm_div: restoring divider, one quotient bit per cycle
// depends on gbsm_pkg
module gbsm_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gbsm_pkg::QUO_W-1:0]  dividend,
   input  logic [gbsm_pkg::CELL_W-1:0] divisor,
   output logic                        done,
   output logic [gbsm_pkg::QUO_W-1:0]  quotient
);
   import gbsm_pkg::*;

   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CELL_W-1:0] rem_ff, rem_in;
   logic [CELL_W-1:0] dvs_ff, dvs_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CELL_W:0]   trial;
   logic [CELL_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[CELL_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CELL_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[src/gbsm_table.sv]
// gbsm_table: per-area memory, one write and one registered read port
// unwritten entries read as zero or as their own index; depends on gbsm_pkg
module gbsm_table #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 15,
   parameter bit IDENT = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import gbsm_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] q_ff;
   logic             qv_ff;
   logic [AW-1:0]    qa_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff  <= mem[rd_addr];
         qv_ff <= vld_ff[rd_addr];
         qa_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      if (qv_ff) begin
         rd_data = q_ff;
      end else if (IDENT) begin
         rd_data = WIDTH'(qa_ff);
      end else begin
         rd_data = '0;
      end
   end

endmodule

[src/grid_binning_with_sparse_merge_top.sv]
// grid_binning_with_sparse_merge_top: grid binning of points with sparse-area merge
// depends on gbsm_pkg, gbsm_div, gbsm_table
//
//  channel | ports                         | direction
//  req     | req_valid req_stall req_data  | op and point in
//  rsp     | rsp_valid rsp_stall rsp_data  | area, count, status out
//  csr     | csr_we csr_addr csr_wdata     | register writes
//
// one item at a time; clear and bad-index/full cases go straight from accept to result
// load runs the 16-step iterative dividers, then index calc, range check and table write
// query reads point store, area map and count table in series
// merge checks each area in turn, plus a sweep of the whole map per moved area
// synchronous reset; the tables clear by valid bits, no clearing pass
// a result waits in the output register under stall while the next beat is taken
module grid_binning_with_sparse_merge_top #(
   parameter int MAX_POINTS = 16384,
   parameter int MAX_AREAS  = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  gbsm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output gbsm_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [gbsm_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [gbsm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gbsm_pkg::*;

   localparam int AW = $clog2(MAX_AREAS);
   localparam int NW = $clog2(MAX_AREAS + 1);
   localparam int PW = $clog2(MAX_POINTS);
   localparam int LW = $clog2(MAX_POINTS + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DIV    = 4'd1;
   localparam logic [3:0] S_CALC   = 4'd2;
   localparam logic [3:0] S_CHECK  = 4'd3;
   localparam logic [3:0] S_LDWR   = 4'd4;
   localparam logic [3:0] S_QPA    = 4'd5;
   localparam logic [3:0] S_QFA    = 4'd6;
   localparam logic [3:0] S_QCNT   = 4'd7;
   localparam logic [3:0] S_MRD    = 4'd8;
   localparam logic [3:0] S_MCHK   = 4'd9;
   localparam logic [3:0] S_MADD   = 4'd10;
   localparam logic [3:0] S_MZERO  = 4'd11;
   localparam logic [3:0] S_MMAP   = 4'd12;
   localparam logic [3:0] S_FIN    = 4'd13;

   // configuration registers
   logic [GRID_W-1:0] rows_ff, cols_ff;
   logic [CELL_W-1:0] cdep_ff, cwid_ff, minp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 7'd4;
         cols_ff <= 7'd6;
         cdep_ff <= 15'd2560;
         cwid_ff <= 15'd2560;
         minp_ff <= 15'd100;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GRID_ROWS:  rows_ff <= csr_wdata[GRID_W-1:0];
            CSR_GRID_COLS:  cols_ff <= csr_wdata[GRID_W-1:0];
            CSR_CELL_DEPTH: cdep_ff <= csr_wdata;
            CSR_CELL_WIDTH: cwid_ff <= csr_wdata;
            CSR_MIN_POINTS: minp_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control and working registers
   logic [3:0]        state_ff, state_in;
   logic [LW-1:0]     loaded_ff, loaded_in;
   logic              xneg_ff, xneg_in;
   logic              ypos_ff, ypos_in;
   logic              ingrid_ff, ingrid_in;
   logic [GRID_W-1:0] side_ff, side_in;
   logic [13:0]       prod_ff, prod_in;
   logic [AW-1:0]     area_ff, area_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [NW-1:0]     i_ff, i_in;
   logic [AW-1:0]     col_ff, col_in;
   logic [AW-1:0]     tgt_ff, tgt_in;
   logic              top_ff, top_in;
   logic [CNT_W-1:0]  ci_ff, ci_in;
   logic [NW-1:0]     j_ff, j_in;
   logic [AW-1:0]     res_area_ff, res_area_in;
   logic [CNT_W-1:0]  res_cnt_ff, res_cnt_in;
   logic [1:0]        res_st_ff, res_st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // point store
   logic [AW-1:0] pmem [MAX_POINTS];
   logic [AW-1:0] pm_q_ff;
   logic          pm_we, pm_re;
   logic [PW-1:0] pm_raddr;

   always_ff @(posedge clock) begin
      if (pm_we) begin
         pmem[loaded_ff[PW-1:0]] <= area_ff;
      end
      if (pm_re) begin
         pm_q_ff <= pmem[pm_raddr];
      end
   end

   // dividers for the forward and side indexes
   logic              div_start;
   logic [QUO_W-1:0]  ax, ay;
   logic [CELL_W-1:0] cd_eff, cw_eff;
   logic              dx_done, dy_done;
   logic [QUO_W-1:0]  qx, qy;

   assign ax     = req_data.x_coord[COORD_W-1] ? QUO_W'(-req_data.x_coord)
                                              : QUO_W'(req_data.x_coord);
   assign ay     = req_data.y_coord[COORD_W-1] ? QUO_W'(-req_data.y_coord)
                                              : QUO_W'(req_data.y_coord);
   assign cd_eff = (cdep_ff == '0) ? CELL_W'(1) : cdep_ff;
   assign cw_eff = (cwid_ff == '0) ? CELL_W'(1) : cwid_ff;

   gbsm_div u_div_x (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(ax), .divisor(cd_eff), .done(dx_done), .quotient(qx)
   );

   gbsm_div u_div_y (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(ay), .divisor(cw_eff), .done(dy_done), .quotient(qy)
   );

   // per-area count and final-area tables
   logic             tb_clear;
   logic             cnt_we, cnt_re;
   logic [AW-1:0]    cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0] cnt_wdata, cnt_q;
   logic             fa_we, fa_re;
   logic [AW-1:0]    fa_waddr, fa_raddr, fa_wdata, fa_q;

   gbsm_table #(.DEPTH(MAX_AREAS), .WIDTH(CNT_W), .IDENT(1'b0)) u_count (
      .clock(clock), .reset(reset), .clear(tb_clear),
      .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_en(cnt_re), .rd_addr(cnt_raddr), .rd_data(cnt_q)
   );

   gbsm_table #(.DEPTH(MAX_AREAS), .WIDTH(AW), .IDENT(1'b1)) u_final (
      .clock(clock), .reset(reset), .clear(tb_clear),
      .wr_en(fa_we), .wr_addr(fa_waddr), .wr_data(fa_wdata),
      .rd_en(fa_re), .rd_addr(fa_raddr), .rd_data(fa_q)
   );

   logic              accept;
   logic              slot_free;
   logic [QUO_W-1:0]  fwd;
   logic              x_out;
   logic [QUO_W+1:0]  side_full;
   logic [13:0]       ncells;
   logic [14:0]       area_sum;
   logic [9:0]        up_sum;
   logic [GRID_W:0]   col_next;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      loaded_in   = loaded_ff;
      xneg_in     = xneg_ff;
      ypos_in     = ypos_ff;
      ingrid_in   = ingrid_ff;
      side_in     = side_ff;
      prod_in     = prod_ff;
      area_in     = area_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      col_in      = col_ff;
      tgt_in      = tgt_ff;
      top_in      = top_ff;
      ci_in       = ci_ff;
      j_in        = j_ff;
      res_area_in = res_area_ff;
      res_cnt_in  = res_cnt_ff;
      res_st_in   = res_st_ff;
      div_start   = 1'b0;
      pm_we       = 1'b0;
      pm_re       = 1'b0;
      pm_raddr    = PW'(req_data.point_index);
      tb_clear    = 1'b0;
      cnt_we      = 1'b0;
      cnt_re      = 1'b0;
      cnt_waddr   = area_ff;
      cnt_raddr   = area_ff;
      cnt_wdata   = cnt_q + CNT_W'(1);
      fa_we       = 1'b0;
      fa_re       = 1'b0;
      fa_waddr    = AW'(j_ff - NW'(1));
      fa_raddr    = j_ff[AW-1:0];
      fa_wdata    = tgt_ff;

      // forward and side index from the quotients
      fwd       = xneg_ff ? '0 : qx;
      x_out     = xneg_ff && (qx != '0);
      side_full = {1'b0, qy, 1'b0} + (QUO_W+2)'(!ypos_ff);
      ncells    = 14'(rows_ff) * 14'(cols_ff);
      area_sum  = {1'b0, prod_ff} + 15'(side_ff);
      up_sum    = 10'(i_ff) + 10'(cols_ff);
      col_next  = (GRID_W+1)'(col_ff) + 8'd1;

      unique case (state_ff)
         S_IDLE: begin
            res_area_in = '0;
            res_cnt_in  = '0;
            res_st_in   = ST_OK;
            if (accept) begin
               unique case (req_data.op)
                  OP_CLEAR: begin
                     tb_clear  = 1'b1;
                     loaded_in = '0;
                     state_in  = S_FIN;
                  end
                  OP_LOAD: begin
                     if (loaded_ff >= LW'(MAX_POINTS)) begin
                        res_st_in = ST_FULL;
                        state_in  = S_FIN;
                     end else begin
                        div_start = 1'b1;
                        xneg_in   = req_data.x_coord[COORD_W-1];
                        ypos_in   = !req_data.y_coord[COORD_W-1] && (req_data.y_coord != '0);
                        state_in  = S_DIV;
                     end
                  end
                  OP_MERGE: begin
                     n_in     = (ncells >= 14'(MAX_AREAS)) ? NW'(MAX_AREAS) : NW'(ncells);
                     i_in     = '0;
                     col_in   = '0;
                     state_in = S_MRD;
                  end
                  OP_QUERY: begin
                     if ((LW+1)'(req_data.point_index) >= (LW+1)'(loaded_ff)) begin
                        res_st_in = ST_BAD_IDX;
                        state_in  = S_FIN;
                     end else begin
                        pm_re    = 1'b1;
                        state_in = S_QPA;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            if (dx_done && dy_done) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            ingrid_in = !x_out && (fwd < QUO_W'(rows_ff))
                        && (side_full < (QUO_W+2)'(cols_ff));
            side_in   = side_full[GRID_W-1:0];
            prod_in   = 14'(fwd[GRID_W-1:0]) * 14'(cols_ff);
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            area_in = area_sum[AW-1:0];
            if (!ingrid_ff || (area_sum >= 15'(MAX_AREAS))) begin
               res_st_in = ST_OUTSIDE;
               state_in  = S_FIN;
            end else begin
               cnt_re    = 1'b1;
               cnt_raddr = area_sum[AW-1:0];
               state_in  = S_LDWR;
            end
         end
         S_LDWR: begin
            // count update and point store write
            cnt_we      = 1'b1;
            pm_we       = 1'b1;
            loaded_in   = loaded_ff + LW'(1);
            res_area_in = area_ff;
            res_cnt_in  = cnt_wdata;
            state_in    = S_FIN;
         end
         S_QPA: begin
            fa_re    = 1'b1;
            fa_raddr = pm_q_ff;
            state_in = S_QFA;
         end
         S_QFA: begin
            area_in   = fa_q;
            cnt_re    = 1'b1;
            cnt_raddr = fa_q;
            state_in  = S_QCNT;
         end
         S_QCNT: begin
            res_area_in = area_ff;
            res_cnt_in  = cnt_q;
            state_in    = S_FIN;
         end
         S_MRD: begin
            if (i_ff >= n_ff) begin
               state_in = S_FIN;
            end else begin
               cnt_re    = 1'b1;
               cnt_raddr = i_ff[AW-1:0];
               state_in  = S_MCHK;
            end
         end
         S_MCHK: begin
            ci_in = cnt_q;
            if (cnt_q < minp_ff && up_sum < 10'(n_ff)) begin
               tgt_in    = up_sum[AW-1:0];
               top_in    = 1'b0;
               cnt_re    = 1'b1;
               cnt_raddr = up_sum[AW-1:0];
               state_in  = S_MADD;
            end else if (cnt_q < minp_ff && col_ff != i_ff[AW-1:0]) begin
               // top row falls back to the bottom-row cell of its column
               tgt_in    = col_ff;
               top_in    = 1'b1;
               cnt_re    = 1'b1;
               cnt_raddr = col_ff;
               state_in  = S_MADD;
            end else begin
               i_in     = i_ff + NW'(1);
               col_in   = (col_next >= (GRID_W+1)'(cols_ff)) ? '0 : AW'(col_next);
               state_in = S_MRD;
            end
         end
         S_MADD: begin
            if (top_ff && cnt_q == '0) begin
               i_in     = i_ff + NW'(1);
               col_in   = (col_next >= (GRID_W+1)'(cols_ff)) ? '0 : AW'(col_next);
               state_in = S_MRD;
            end else begin
               cnt_we    = 1'b1;
               cnt_waddr = tgt_ff;
               cnt_wdata = cnt_q + ci_ff;
               state_in  = S_MZERO;
            end
         end
         S_MZERO: begin
            cnt_we    = 1'b1;
            cnt_waddr = i_ff[AW-1:0];
            cnt_wdata = '0;
            j_in      = '0;
            state_in  = S_MMAP;
         end
         S_MMAP: begin
            // sweep the map: read entry j, rewrite entry j-1 if it pointed here
            fa_re = (j_ff < NW'(MAX_AREAS));
            if (j_ff != '0 && fa_q == i_ff[AW-1:0]) begin
               fa_we = 1'b1;
            end
            if (j_ff == NW'(MAX_AREAS)) begin
               i_in     = i_ff + NW'(1);
               col_in   = (col_next >= (GRID_W+1)'(cols_ff)) ? '0 : AW'(col_next);
               state_in = S_MRD;
            end else begin
               j_in = j_ff + NW'(1);
            end
         end
         S_FIN: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == S_FIN && slot_free) begin
         rsp_valid_in       = 1'b1;
         rsp_in.area        = AREA_W'(res_area_ff);
         rsp_in.area_points = res_cnt_ff;
         rsp_in.status      = res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      xneg_ff     <= xneg_in;
      ypos_ff     <= ypos_in;
      ingrid_ff   <= ingrid_in;
      side_ff     <= side_in;
      prod_ff     <= prod_in;
      area_ff     <= area_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      col_ff      <= col_in;
      tgt_ff      <= tgt_in;
      top_ff      <= top_in;
      ci_ff       <= ci_in;
      j_ff        <= j_in;
      res_area_ff <= res_area_in;
      res_cnt_ff  <= res_cnt_in;
      res_st_ff   <= res_st_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
